@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the altitude-hold controller.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check that is switched off while reset is held.
`define AVC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Clocked check that also holds while reset is held.
`define AVC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define AVC_ASSERT(label, prop, msg)
`define AVC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ rtl/core/avcpid_pkg.sv @@
// Shared widths, limits, register indexes and helper functions of the
// altitude-hold controller. Depends on nothing.
package avcpid_pkg;

    // Field and datapath widths.
    localparam int ALT_W       = 24;
    localparam int VEL_W       = 16;
    localparam int ACC_W       = 16;
    localparam int ANG_W       = 12;
    localparam int GAIN_W      = 8;
    localparam int MUL_A_W     = 17;
    localparam int PROD_W      = 25;
    localparam int INTEG_W     = 19;
    localparam int DRIVE_W     = 11;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ALT_P_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_P_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_I_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_D_GAIN = 2'd3;

    // Gain values after reset.
    localparam logic [GAIN_W-1:0] RST_ALT_P_GAIN = 8'd50;
    localparam logic [GAIN_W-1:0] RST_VEL_P_GAIN = 8'd120;
    localparam logic [GAIN_W-1:0] RST_VEL_I_GAIN = 8'd45;
    localparam logic [GAIN_W-1:0] RST_VEL_D_GAIN = 8'd1;

    // Symmetric limits, held at the full datapath width.
    localparam logic signed [PROD_W-1:0] ALT_ERR_LIM        = 25'sd500;
    localparam logic signed [PROD_W-1:0] ALT_ERROR_DEADBAND = 25'sd10;
    localparam logic signed [PROD_W-1:0] SETV_LIM           = 25'sd300;
    localparam logic signed [PROD_W-1:0] VEL_P_LIM          = 25'sd300;
    localparam logic signed [PROD_W-1:0] INTEG_LIM          = 25'sd204800;
    localparam logic signed [PROD_W-1:0] VEL_D_LIM          = 25'sd150;

    // Tilt threshold in tenths of a degree, compared against a magnitude.
    localparam logic [ANG_W:0] TILT_LIMIT = 13'd800;

    // Power-of-two divisors, as shift counts.
    localparam int SETV_SHIFT  = 7;
    localparam int VEL_P_SHIFT = 5;
    localparam int VEL_I_SHIFT = 3;
    localparam int VEL_D_SHIFT = 6;
    localparam int INTEG_SHIFT = 10;

    // Signed division by 2**sh that truncates toward zero.
    function automatic logic signed [PROD_W-1:0] div_pow2(
        input logic signed [PROD_W-1:0] x,
        input int unsigned              sh
    );
        logic signed [PROD_W-1:0] bias;
        bias = '0;
        if (x[PROD_W-1]) begin
            bias = signed'(PROD_W'((1 << sh) - 1));
        end
        return (x + bias) >>> sh;
    endfunction

    // Clamp to the range -lim .. lim.
    function automatic logic signed [PROD_W-1:0] clamp_sym(
        input logic signed [PROD_W-1:0] x,
        input logic signed [PROD_W-1:0] lim
    );
        logic signed [PROD_W-1:0] res;
        res = x;
        if (x > lim) begin
            res = lim;
        end else if (x < -lim) begin
            res = -lim;
        end
        return res;
    endfunction

endpackage

@@ rtl/core/avcpid_ser_mul.sv @@
// Bit-serial multiplier: signed operand times an unsigned 8-bit gain.
// Depends on avcpid_pkg for the operand and product widths.
module avcpid_ser_mul (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [avcpid_pkg::MUL_A_W-1:0]  i_a,
    input  logic        [avcpid_pkg::GAIN_W-1:0]   i_b,
    output logic                                   o_done,
    output logic signed [avcpid_pkg::PROD_W-1:0]   o_prod
);
    import avcpid_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_W - 1);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [MUL_A_W-1:0] r_a;
    logic [GAIN_W-1:0]         r_b;
    logic signed [PROD_W-1:0]  r_acc;
    logic signed [PROD_W-1:0]  n_acc;
    logic signed [PROD_W-1:0]  w_addend;

    // One gain bit per cycle, most significant first: double and add.
    always_comb begin
        w_addend = '0;
        if (r_b[GAIN_W-1]) begin
            w_addend = {{(PROD_W - MUL_A_W){r_a[MUL_A_W-1]}}, r_a};
        end
        n_acc = (r_acc <<< 1) + w_addend;
    end

    // Bit counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and accumulator shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= r_b << 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ rtl/core/altitude_velocity_cascaded_pid_unit.sv @@
// Top level of the cascaded altitude-hold controller.
// Depends on avcpid_pkg, avcpid_ser_mul and assert_macros.svh.
//
// An outer altitude P loop feeds an inner vertical-velocity PID loop; each
// accepted beat gives one throttle correction. All four gain products go
// through one bit-serial multiplier, one after another, so an item that is
// not tilted passes through every product state before it reaches the output
// register. A tilted item needs no products: it goes from acceptance through
// S_OUT straight to the output register. A new beat is accepted as soon as
// the previous result sits in the output register, even if it has not yet
// been taken. The gains may be rewritten only while the block is idle.
`include "assert_macros.svh"

module altitude_velocity_cascaded_pid_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // Input stream.
    input  logic                                     i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // From bit 0: target_altitude[24], estimated_altitude[24],
    // vertical_velocity[16], vertical_accel[16], roll_decideg[12],
    // pitch_decideg[12].
    input  logic [avcpid_pkg::IN_TDATA_W-1:0]        i_s_axis_tdata,
    // Output stream.
    output logic                                     o_m_axis_tvalid,
    input  logic                                     i_m_axis_tready,
    // From bit 0: throttle_drive[11], then zero padding.
    output logic [avcpid_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    // Bit 0: tilted.
    output logic [0:0]                               o_m_axis_tuser,
    // Gain register writes.
    input  logic                                     i_cfg_wr_en,
    input  logic [avcpid_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [avcpid_pkg::GAIN_W-1:0]            i_cfg_wdata
);
    import avcpid_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ALT_GO, S_ALT_WAIT, S_VERR, S_P_GO, S_P_WAIT, S_I_GO,
        S_I_WAIT, S_INTEG, S_D_GO, S_D_WAIT, S_SUM, S_OUT
    } t_state;

    t_state r_state;

    // Gains.
    logic [GAIN_W-1:0] r_alt_p_gain;
    logic [GAIN_W-1:0] r_vel_p_gain;
    logic [GAIN_W-1:0] r_vel_i_gain;
    logic [GAIN_W-1:0] r_vel_d_gain;

    // Loop state.
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ACC_W-1:0]   r_prev_acc;

    // Per-item working registers.
    logic                      r_tilt;
    logic signed [9:0]         r_err;
    logic signed [VEL_W-1:0]   r_vel;
    logic signed [MUL_A_W-1:0] r_acc_sum;
    logic signed [9:0]         r_setv;
    logic signed [MUL_A_W-1:0] r_verr;
    logic signed [9:0]         r_p;
    logic signed [21:0]        r_iadd;
    logic signed [8:0]         r_d;
    logic signed [DRIVE_W-1:0] r_drive;

    // Output register.
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_out_drive;
    logic                      r_out_tilt;

    // Input field view.
    logic signed [ALT_W-1:0] w_tgt;
    logic signed [ALT_W-1:0] w_est;
    logic signed [VEL_W-1:0] w_vel;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [ANG_W-1:0] w_roll;
    logic signed [ANG_W-1:0] w_pitch;

    logic                      w_accept;
    logic [ANG_W:0]            w_roll_abs;
    logic [ANG_W:0]            w_pitch_abs;
    logic                      w_tilt;
    logic signed [PROD_W-1:0]  w_diff;
    logic signed [PROD_W-1:0]  w_err_cl;
    logic signed [PROD_W-1:0]  w_err_dz;
    logic signed [MUL_A_W-1:0] w_acc_sum;

    // Multiplier connection.
    logic                      w_mul_start;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic [GAIN_W-1:0]         w_mul_b;
    logic                      w_mul_done;
    logic signed [PROD_W-1:0]  w_prod;

    // Arithmetic after each product.
    logic signed [PROD_W-1:0]  w_setv;
    logic signed [PROD_W-1:0]  w_p;
    logic signed [PROD_W-1:0]  w_iadd;
    logic signed [PROD_W-1:0]  w_d;
    logic signed [PROD_W-1:0]  w_integ_sum;
    logic signed [PROD_W-1:0]  w_integ_cl;
    logic signed [PROD_W-1:0]  w_integ_q;
    logic signed [MUL_A_W-1:0] w_verr;
    logic signed [DRIVE_W-1:0] w_drive;

    assign w_tgt   = i_s_axis_tdata[23:0];
    assign w_est   = i_s_axis_tdata[47:24];
    assign w_vel   = i_s_axis_tdata[63:48];
    assign w_acc   = i_s_axis_tdata[79:64];
    assign w_roll  = i_s_axis_tdata[91:80];
    assign w_pitch = i_s_axis_tdata[103:92];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Tilt test, altitude error clamp and deadband, and acceleration sum on the incoming beat.
    always_comb begin
        w_roll_abs  = w_roll[ANG_W-1]  ? -{w_roll[ANG_W-1], w_roll}
                                       :  {w_roll[ANG_W-1], w_roll};
        w_pitch_abs = w_pitch[ANG_W-1] ? -{w_pitch[ANG_W-1], w_pitch}
                                       :  {w_pitch[ANG_W-1], w_pitch};
        w_tilt      = (w_roll_abs >= TILT_LIMIT) || (w_pitch_abs >= TILT_LIMIT);

        w_diff   = {w_tgt[ALT_W-1], w_tgt} - {w_est[ALT_W-1], w_est};
        w_err_cl = clamp_sym(w_diff, ALT_ERR_LIM);
        if (w_err_cl < ALT_ERROR_DEADBAND && w_err_cl > -ALT_ERROR_DEADBAND) begin
            w_err_dz = '0;
        end else if (w_err_cl > 0) begin
            w_err_dz = w_err_cl - ALT_ERROR_DEADBAND;
        end else begin
            w_err_dz = w_err_cl + ALT_ERROR_DEADBAND;
        end

        w_acc_sum = {w_acc[ACC_W-1], w_acc} + {r_prev_acc[ACC_W-1], r_prev_acc};
    end

    // Operand selection for the shared multiplier.
    assign w_mul_start = r_state inside {S_ALT_GO, S_P_GO, S_I_GO, S_D_GO};

    always_comb begin
        case (r_state)
            S_ALT_GO: begin
                w_mul_a = {{(MUL_A_W - 10){r_err[9]}}, r_err};
                w_mul_b = r_alt_p_gain;
            end
            S_P_GO: begin
                w_mul_a = r_verr;
                w_mul_b = r_vel_p_gain;
            end
            S_I_GO: begin
                w_mul_a = r_verr;
                w_mul_b = r_vel_i_gain;
            end
            S_D_GO: begin
                w_mul_a = r_acc_sum;
                w_mul_b = r_vel_d_gain;
            end
            default: begin
                w_mul_a = r_verr;
                w_mul_b = r_vel_p_gain;
            end
        endcase
    end

    avcpid_ser_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // Product scaling and limits (the integral sum is clamped instead), velocity error, integrator sum, final sum.
    always_comb begin
        w_setv = clamp_sym(div_pow2(w_prod, SETV_SHIFT), SETV_LIM);
        w_p    = clamp_sym(div_pow2(w_prod, VEL_P_SHIFT), VEL_P_LIM);
        w_iadd = div_pow2(w_prod, VEL_I_SHIFT);
        w_d    = clamp_sym(div_pow2(w_prod, VEL_D_SHIFT), VEL_D_LIM);

        w_verr = {{(MUL_A_W - 10){r_setv[9]}}, r_setv} - {r_vel[VEL_W-1], r_vel};

        w_integ_sum = {{(PROD_W - INTEG_W){r_integ[INTEG_W-1]}}, r_integ}
                    + {{(PROD_W - 22){r_iadd[21]}}, r_iadd};
        w_integ_cl  = clamp_sym(w_integ_sum, INTEG_LIM);

        w_integ_q = div_pow2({{(PROD_W - INTEG_W){r_integ[INTEG_W-1]}}, r_integ},
                             INTEG_SHIFT);
        w_drive   = {{(DRIVE_W - 10){r_p[9]}}, r_p}
                  + w_integ_q[DRIVE_W-1:0]
                  - {{(DRIVE_W - 9){r_d[8]}}, r_d};
    end

    // Gain register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt_p_gain <= RST_ALT_P_GAIN;
            r_vel_p_gain <= RST_VEL_P_GAIN;
            r_vel_i_gain <= RST_VEL_I_GAIN;
            r_vel_d_gain <= RST_VEL_D_GAIN;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_ALT_P_GAIN: r_alt_p_gain <= i_cfg_wdata;
                REG_VEL_P_GAIN: r_vel_p_gain <= i_cfg_wdata;
                REG_VEL_I_GAIN: r_vel_i_gain <= i_cfg_wdata;
                REG_VEL_D_GAIN: r_vel_d_gain <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer: state, loop state, working registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_integ     <= '0;
            r_prev_acc  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A taken beat empties the output register unless S_OUT refills it.
            if (r_out_valid && i_m_axis_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_tilt     <= w_tilt;
                        r_err      <= w_err_dz[9:0];
                        r_vel      <= w_vel;
                        r_acc_sum  <= w_acc_sum;
                        r_prev_acc <= w_acc;
                        r_drive    <= '0;
                        r_state    <= w_tilt ? S_OUT : S_ALT_GO;
                    end
                end
                S_ALT_GO: r_state <= S_ALT_WAIT;
                S_ALT_WAIT: begin
                    if (w_mul_done) begin
                        r_setv  <= w_setv[9:0];
                        r_state <= S_VERR;
                    end
                end
                S_VERR: begin
                    r_verr  <= w_verr;
                    r_state <= S_P_GO;
                end
                S_P_GO: r_state <= S_P_WAIT;
                S_P_WAIT: begin
                    if (w_mul_done) begin
                        r_p     <= w_p[9:0];
                        r_state <= S_I_GO;
                    end
                end
                S_I_GO: r_state <= S_I_WAIT;
                S_I_WAIT: begin
                    if (w_mul_done) begin
                        r_iadd  <= w_iadd[21:0];
                        r_state <= S_INTEG;
                    end
                end
                S_INTEG: begin
                    r_integ <= w_integ_cl[INTEG_W-1:0];
                    r_state <= S_D_GO;
                end
                S_D_GO: r_state <= S_D_WAIT;
                S_D_WAIT: begin
                    if (w_mul_done) begin
                        r_d     <= w_d[8:0];
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_drive <= w_drive;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_drive <= r_drive;
                        r_out_tilt  <= r_tilt;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - DRIVE_W){1'b0}}, r_out_drive};
    assign o_m_axis_tuser  = r_out_tilt;

    // A tilted result carries a zero drive.
    `AVC_ASSERT(a_tilt_zero, (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0), "tilted beat with non-zero drive")
    // The integrator never leaves its saturation band.
    `AVC_ASSERT(a_integ_range, (r_integ <= INTEG_LIM && r_integ >= -INTEG_LIM), "integrator outside its limits")
    // An accepted beat closes the input side for at least the next cycle.
    `AVC_ASSERT(a_one_item, w_accept |=> !o_s_axis_tready, "second beat accepted while busy")
    // A finished result is not dropped over one that is still waiting.
    `AVC_ASSERT(a_no_overwrite, (r_state == S_OUT && r_out_valid && !i_m_axis_tready) |=> (r_state == S_OUT), "pending result overwritten")

endmodule
